/* rtl/uart_rf_pkg.sv */
// uart_rf_pkg: shared widths, request and register codes, state and command types
// for the uart register file with fifos; no dependencies
`default_nettype none

package uart_rf_pkg;

  // default fifo depth and field widths
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int TYPE_W = 3;
  localparam int OFS_W  = 8;
  localparam int AW_W   = 2;
  localparam int DATA_W = 8;
  localparam int ERR_W  = 2;
  localparam int IER_W  = 4;
  localparam int MCR_W  = 5;

  // request types
  localparam logic [TYPE_W-1:0] REQ_READ   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_ATOMIC = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RX     = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_TXPOP  = 3'd4;

  localparam logic [AW_W-1:0] WIDTH_BYTE = 2'd0;

  // bus error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_WIDTH  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OFFSET = 2'd2;
  localparam logic [ERR_W-1:0] ERR_ATOMIC = 2'd3;

  // register map
  localparam logic [OFS_W-1:0] OFS_LAST = 8'd7;
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  // bit positions
  localparam int LCR_DLAB_BIT   = 7;
  localparam int FCR_ENABLE_BIT = 0;
  localparam int FCR_RX_CLR_BIT = 1;
  localparam int FCR_TX_CLR_BIT = 2;
  localparam int IER_RDA_BIT    = 0;
  localparam int IER_THRE_BIT   = 1;
  localparam int IER_RLS_BIT    = 2;

  // register masks and fixed values
  localparam logic [DATA_W-1:0] FCR_MASK    = 8'hC9;
  localparam logic [MCR_W-1:0]  MCR_MASK    = 5'h1F;
  localparam logic [DATA_W-1:0] IIR_BASE    = 8'hC0;
  localparam logic [DATA_W-1:0] LSR_BASE    = 8'h60;
  localparam logic [DATA_W-1:0] LSR_DR      = 8'h01;
  localparam logic [DATA_W-1:0] LSR_OE      = 8'h02;
  localparam logic [DATA_W-1:0] IIR_ID_RLS  = 8'h06;
  localparam logic [DATA_W-1:0] IIR_ID_RDA  = 8'h04;
  localparam logic [DATA_W-1:0] IIR_ID_THRE = 8'h02;
  localparam logic [DATA_W-1:0] IIR_ID_NONE = 8'h01;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic ld_item;
    logic exec;
    logic ld_out;
  } cmd_t;

  // index width of a store, at least one bit
  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

/* rtl/uart_rf_req_if.sv */
// uart_rf_req_if: request channel (valid, ready, request fields)
// depends on uart_rf_pkg
`default_nettype none

interface uart_rf_req_if;
  import uart_rf_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [OFS_W-1:0]  reg_offset;
  logic [AW_W-1:0]   access_width;
  logic [DATA_W-1:0] write_data;
  logic [DATA_W-1:0] rx_byte;

  modport source (output valid, req_type, reg_offset, access_width, write_data, rx_byte,
                  input ready);
  modport sink   (input valid, req_type, reg_offset, access_width, write_data, rx_byte,
                  output ready);
endinterface

`default_nettype wire

/* rtl/uart_rf_rsp_if.sv */
// uart_rf_rsp_if: result channel (valid, ready, result fields)
// depends on uart_rf_pkg
`default_nettype none

interface uart_rf_rsp_if;
  import uart_rf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [ERR_W-1:0]  bus_error;
  logic              rx_accepted;
  logic              tx_valid;
  logic [DATA_W-1:0] tx_byte;
  logic              irq_level;

  modport source (output valid, read_data, bus_error, rx_accepted, tx_valid, tx_byte,
                  irq_level, input ready);
  modport sink   (input valid, read_data, bus_error, rx_accepted, tx_valid, tx_byte,
                  irq_level, output ready);
endinterface

`default_nettype wire

/* rtl/uart_rf_ram.sv */
// uart_rf_ram: generic single write port, single read port ram with registered read
// depends on uart_rf_pkg for defaults
`default_nettype none

module uart_rf_ram #(
  parameter int WIDTH = uart_rf_pkg::DATA_W,
  parameter int DEPTH = uart_rf_pkg::FIFO_DEPTH_DEF,
  localparam int ADDR_W = uart_rf_pkg::idx_width(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

/* rtl/uart_rf_ctrl.sv */
// uart_rf_ctrl: sequencer for one request at a time, output valid flag
// depends on uart_rf_pkg
`default_nettype none

module uart_rf_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output uart_rf_pkg::cmd_t cmd
);
  import uart_rf_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        // result slot free or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd.ld_out     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_EXEC && !in_ready))
    else $error("accepted request did not move to execute");

  a_exec_to_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> (state == ST_WAIT))
    else $error("execute step not followed by result wait");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |=> (out_valid && state == ST_IDLE))
    else $error("result load did not raise output valid");
`endif
endmodule

`default_nettype wire

/* rtl/uart_rf_dp.sv */
// uart_rf_dp: register file, fifo pointers and stores, result register
// depends on uart_rf_pkg and uart_rf_ram
`default_nettype none

module uart_rf_dp #(
  parameter int FIFO_DEPTH = uart_rf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire uart_rf_pkg::cmd_t                cmd,
  input  wire logic [uart_rf_pkg::TYPE_W-1:0]   req_type,
  input  wire logic [uart_rf_pkg::OFS_W-1:0]    reg_offset,
  input  wire logic [uart_rf_pkg::AW_W-1:0]     access_width,
  input  wire logic [uart_rf_pkg::DATA_W-1:0]   write_data,
  input  wire logic [uart_rf_pkg::DATA_W-1:0]   rx_byte,
  output logic      [uart_rf_pkg::DATA_W-1:0]   read_data,
  output logic      [uart_rf_pkg::ERR_W-1:0]    bus_error,
  output logic                                  rx_accepted,
  output logic                                  tx_valid,
  output logic      [uart_rf_pkg::DATA_W-1:0]   tx_byte,
  output logic                                  irq_level
);
  import uart_rf_pkg::*;

  localparam int IDX_W = idx_width(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // latched request
  logic [TYPE_W-1:0] it_type;
  logic [OFS_W-1:0]  it_off;
  logic [AW_W-1:0]   it_width;
  logic [DATA_W-1:0] it_wdata;
  logic [DATA_W-1:0] it_rxb;

  // register file
  logic [DATA_W-1:0] lcr, lcr_next;
  logic [IER_W-1:0]  ier, ier_next;
  logic [DATA_W-1:0] dll, dll_next;
  logic [DATA_W-1:0] dlm, dlm_next;
  logic [DATA_W-1:0] fcr, fcr_next;
  logic [MCR_W-1:0]  mcr, mcr_next;
  logic [DATA_W-1:0] scr, scr_next;
  logic              ovr, ovr_next;

  // fifo pointers
  logic [CNT_W-1:0] rx_count, rx_count_next, tx_count, tx_count_next;
  logic [IDX_W-1:0] rx_head, rx_head_next, tx_head, tx_head_next;
  logic [IDX_W-1:0] rx_head_inc, tx_head_inc, rx_tail, tx_tail;
  logic [SUM_W-1:0] rx_sum, tx_sum;

  // store ports
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [DATA_W-1:0] rx_q, tx_q;

  // pending result
  logic [DATA_W-1:0] res_rdata, p_rdata;
  logic [ERR_W-1:0]  res_err, p_err;
  logic              res_rxok, p_rxok, res_txv, p_txv, res_use_rx, p_use_rx;

  logic              dlab, rx_empty, rx_full, tx_empty, tx_full;
  logic [2:0]        reg_sel;
  logic [DATA_W-1:0] iir_id;
  logic              irq_now;

  assign dlab     = lcr[LCR_DLAB_BIT];
  assign reg_sel  = it_off[2:0];
  assign rx_empty = (rx_count == '0);
  assign tx_empty = (tx_count == '0);
  assign rx_full  = (rx_count == CNT_W'(FIFO_DEPTH));
  assign tx_full  = (tx_count == CNT_W'(FIFO_DEPTH));

  // head advance and tail position, wrapped at the depth
  assign rx_head_inc = (rx_head == IDX_W'(FIFO_DEPTH - 1)) ? '0 : rx_head + IDX_W'(1);
  assign tx_head_inc = (tx_head == IDX_W'(FIFO_DEPTH - 1)) ? '0 : tx_head + IDX_W'(1);
  always_comb begin
    logic [SUM_W-1:0] rx_wrap, tx_wrap;
    rx_sum  = SUM_W'(rx_head) + SUM_W'(rx_count);
    tx_sum  = SUM_W'(tx_head) + SUM_W'(tx_count);
    rx_wrap = (rx_sum >= SUM_W'(FIFO_DEPTH)) ? rx_sum - SUM_W'(FIFO_DEPTH) : rx_sum;
    tx_wrap = (tx_sum >= SUM_W'(FIFO_DEPTH)) ? tx_sum - SUM_W'(FIFO_DEPTH) : tx_sum;
    rx_tail = rx_wrap[IDX_W-1:0];
    tx_tail = tx_wrap[IDX_W-1:0];
  end

  // prioritized interrupt id
  always_comb begin
    if (ier[IER_RLS_BIT] && ovr) begin
      iir_id = IIR_ID_RLS;
    end else if (ier[IER_RDA_BIT] && !rx_empty) begin
      iir_id = IIR_ID_RDA;
    end else if (ier[IER_THRE_BIT] && tx_empty) begin
      iir_id = IIR_ID_THRE;
    end else begin
      iir_id = IIR_ID_NONE;
    end
  end
  assign irq_now = (iir_id != IIR_ID_NONE);

  // request decode and state update
  always_comb begin
    lcr_next      = lcr;
    ier_next      = ier;
    dll_next      = dll;
    dlm_next      = dlm;
    fcr_next      = fcr;
    mcr_next      = mcr;
    scr_next      = scr;
    ovr_next      = ovr;
    rx_count_next = rx_count;
    tx_count_next = tx_count;
    rx_head_next  = rx_head;
    tx_head_next  = tx_head;
    res_rdata     = '0;
    res_err       = ERR_NONE;
    res_rxok      = 1'b0;
    res_txv       = 1'b0;
    res_use_rx    = 1'b0;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    if (cmd.exec) begin
      case (it_type)
        REQ_READ, REQ_WRITE: begin
          if (it_width != WIDTH_BYTE) begin
            res_err = ERR_WIDTH;
          end else if (it_off > OFS_LAST) begin
            res_err = ERR_OFFSET;
          end else if (it_type == REQ_READ) begin
            case (reg_sel)
              REG_DATA: begin
                if (dlab) begin
                  res_rdata = dll;
                end else if (!rx_empty) begin
                  rx_re         = 1'b1;
                  res_use_rx    = 1'b1;
                  rx_head_next  = rx_head_inc;
                  rx_count_next = rx_count - CNT_W'(1);
                end
              end
              REG_IER:     res_rdata = dlab ? dlm : DATA_W'(ier);
              REG_IIR_FCR: res_rdata = IIR_BASE | iir_id;
              REG_LCR:     res_rdata = lcr;
              REG_MCR:     res_rdata = DATA_W'(mcr);
              REG_LSR: begin
                res_rdata = LSR_BASE | (rx_empty ? '0 : LSR_DR) | (ovr ? LSR_OE : '0);
                ovr_next  = 1'b0;
              end
              REG_MSR:     res_rdata = '0;
              REG_SCR:     res_rdata = scr;
              default:     res_rdata = '0;
            endcase
          end else begin
            case (reg_sel)
              REG_DATA: begin
                if (dlab) begin
                  dll_next = it_wdata;
                end else if (!tx_full) begin
                  tx_we         = 1'b1;
                  tx_count_next = tx_count + CNT_W'(1);
                end
              end
              REG_IER: begin
                if (dlab) begin
                  dlm_next = it_wdata;
                end else begin
                  ier_next = it_wdata[IER_W-1:0];
                end
              end
              REG_IIR_FCR: begin
                fcr_next = it_wdata[FCR_ENABLE_BIT] ? (it_wdata & FCR_MASK) : '0;
                if (it_wdata[FCR_RX_CLR_BIT]) begin
                  rx_count_next = '0;
                  rx_head_next  = '0;
                  ovr_next      = 1'b0;
                end
                if (it_wdata[FCR_TX_CLR_BIT]) begin
                  tx_count_next = '0;
                  tx_head_next  = '0;
                end
              end
              REG_LCR: lcr_next = it_wdata;
              REG_MCR: mcr_next = it_wdata[MCR_W-1:0] & MCR_MASK;
              REG_SCR: scr_next = it_wdata;
              default: begin
              end
            endcase
          end
        end
        REQ_ATOMIC: begin
          res_err = ERR_ATOMIC;
        end
        REQ_RX: begin
          if (rx_full) begin
            ovr_next = 1'b1;
          end else begin
            rx_we         = 1'b1;
            rx_count_next = rx_count + CNT_W'(1);
            res_rxok      = 1'b1;
          end
        end
        REQ_TXPOP: begin
          if (!tx_empty) begin
            tx_re         = 1'b1;
            tx_head_next  = tx_head_inc;
            tx_count_next = tx_count - CNT_W'(1);
            res_txv       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control and register file state
  always_ff @(posedge clk) begin
    if (rst) begin
      lcr      <= '0;
      ier      <= '0;
      dll      <= '0;
      dlm      <= '0;
      fcr      <= '0;
      mcr      <= '0;
      scr      <= '0;
      ovr      <= 1'b0;
      rx_count <= '0;
      tx_count <= '0;
      rx_head  <= '0;
      tx_head  <= '0;
    end else begin
      lcr      <= lcr_next;
      ier      <= ier_next;
      dll      <= dll_next;
      dlm      <= dlm_next;
      fcr      <= fcr_next;
      mcr      <= mcr_next;
      scr      <= scr_next;
      ovr      <= ovr_next;
      rx_count <= rx_count_next;
      tx_count <= tx_count_next;
      rx_head  <= rx_head_next;
      tx_head  <= tx_head_next;
    end
  end

  // request latch, pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      it_type  <= req_type;
      it_off   <= reg_offset;
      it_width <= access_width;
      it_wdata <= write_data;
      it_rxb   <= rx_byte;
    end
    if (cmd.exec) begin
      p_rdata  <= res_rdata;
      p_err    <= res_err;
      p_rxok   <= res_rxok;
      p_txv    <= res_txv;
      p_use_rx <= res_use_rx;
    end
    if (cmd.ld_out) begin
      read_data   <= p_use_rx ? rx_q : p_rdata;
      bus_error   <= p_err;
      rx_accepted <= p_rxok;
      tx_valid    <= p_txv;
      tx_byte     <= p_txv ? tx_q : '0;
      irq_level   <= irq_now;
    end
  end

  // byte stores
  uart_rf_ram #(.WIDTH(DATA_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail),
    .wdata (it_rxb),
    .re    (rx_re),
    .raddr (rx_head),
    .rdata (rx_q)
  );

  uart_rf_ram #(.WIDTH(DATA_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail),
    .wdata (it_wdata),
    .re    (tx_re),
    .raddr (tx_head),
    .rdata (tx_q)
  );

`ifndef SYNTHESIS
  a_rx_count_bound: assert property (@(posedge clk) disable iff (rst)
    (rx_count <= CNT_W'(FIFO_DEPTH)) && (rx_head <= IDX_W'(FIFO_DEPTH - 1)))
    else $error("receive fifo pointers out of range");

  a_tx_count_bound: assert property (@(posedge clk) disable iff (rst)
    (tx_count <= CNT_W'(FIFO_DEPTH)) && (tx_head <= IDX_W'(FIFO_DEPTH - 1)))
    else $error("transmit fifo pointers out of range");

  a_overrun_on_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && it_type == REQ_RX && rx_full) |=> (ovr && rx_count == CNT_W'(FIFO_DEPTH)))
    else $error("arrival at full receive fifo did not set overrun");
`endif
endmodule

`default_nettype wire

/* rtl/uart_register_file_with_fifos_unit.sv */
// uart_register_file_with_fifos_unit: top level, controller plus datapath
// depends on uart_rf_pkg, uart_rf_req_if, uart_rf_rsp_if, uart_rf_ctrl, uart_rf_dp
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, reg_offset, access_width, write_data, rx_byte
//   rsp      out  valid/ready    read_data, bus_error, rx_accepted, tx_valid, tx_byte,
//                                irq_level
//
// each request steps through accept, execute (register and fifo pointer
// update, fifo ram read issued), then result, where the registered ram read lands in
// the result register; a new request is accepted only after that result step
// the result register lets the next request in while the last result waits on rsp
// a stalled rsp holds the sequencer in its result step until the register frees
// synchronous reset clears registers and fifo counts; the fifo rams need no clearing
`default_nettype none

module uart_register_file_with_fifos_unit #(
  parameter int FIFO_DEPTH = uart_rf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  uart_rf_req_if.sink   req,
  uart_rf_rsp_if.source rsp
);
  import uart_rf_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  // sequencer
  uart_rf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // register file and fifos
  uart_rf_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req.req_type),
    .reg_offset   (req.reg_offset),
    .access_width (req.access_width),
    .write_data   (req.write_data),
    .rx_byte      (req.rx_byte),
    .read_data    (rsp.read_data),
    .bus_error    (rsp.bus_error),
    .rx_accepted  (rsp.rx_accepted),
    .tx_valid     (rsp.tx_valid),
    .tx_byte      (rsp.tx_byte),
    .irq_level    (rsp.irq_level)
  );
endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench for uart_register_file_with_fifos_unit
// depends on uart_rf_pkg, uart_rf_req_if, uart_rf_rsp_if and the unit itself
module tb_top;
  import uart_rf_pkg::*;

  localparam int          ITEMS_TARGET = 1750;
  localparam int          QUIET_ITEMS  = 150;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          DEPTH        = FIFO_DEPTH_DEF;
  // request types and widths that the block treats as invalid
  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [AW_W-1:0]   WIDTH_HALF    = 2'd1;
  localparam logic [AW_W-1:0]   WIDTH_DWORD   = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [OFS_W-1:0]  offset;
    logic [AW_W-1:0]   width;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rxb;
  } bus_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ERR_W-1:0]  bus_error;
    logic              rx_accepted;
    logic              tx_valid;
    logic [DATA_W-1:0] tx_byte;
    logic              irq_level;
  } uart_rsp_t;

  bit   clk = 1'b0;
  logic rst;

  uart_rf_req_if req ();
  uart_rf_rsp_if rsp ();

  uart_register_file_with_fifos_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // shadow copy of the uart registers and fifos
  logic [DATA_W-1:0] lcr_q, dll_q, dlm_q, scr_q;
  logic [IER_W-1:0]  ier_q;
  logic [MCR_W-1:0]  mcr_q;
  logic              overrun_q;
  logic [DATA_W-1:0] rx_fifo_q[$];
  logic [DATA_W-1:0] tx_fifo_q[$];

  uart_rsp_t   expected_rsps[$];
  uart_rsp_t   got_rsp, want_rsp;
  int unsigned gap_pct, stall_pct;
  bit          quiet;
  int          n_items, n_checked, n_fail, n_cycles;
  int          n_overruns, n_tx_drops, n_bus_errors, n_rx_reads, n_tx_pops;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               expected_rsps.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // prioritized interrupt id as seen in iir
  function automatic logic [DATA_W-1:0] irq_ident();
    if (ier_q[IER_RLS_BIT] && overrun_q) return IIR_ID_RLS;
    if (ier_q[IER_RDA_BIT] && rx_fifo_q.size() != 0) return IIR_ID_RDA;
    if (ier_q[IER_THRE_BIT] && tx_fifo_q.size() == 0) return IIR_ID_THRE;
    return IIR_ID_NONE;
  endfunction

  // apply one request to the shadow state and return the result it produces
  function automatic uart_rsp_t predict_response(input bus_req_t r);
    uart_rsp_t   p;
    logic        dlab;
    logic [2:0]  a;
    p    = '0;
    dlab = lcr_q[LCR_DLAB_BIT];
    a    = r.offset[2:0];
    case (r.kind)
      REQ_READ, REQ_WRITE: begin
        if (r.width != WIDTH_BYTE) begin
          p.bus_error = ERR_WIDTH;
        end else if (r.offset > OFS_LAST) begin
          p.bus_error = ERR_OFFSET;
        end else if (r.kind == REQ_READ) begin
          case (a)
            REG_DATA: begin
              if (dlab) begin
                p.read_data = dll_q;
              end else if (rx_fifo_q.size() != 0) begin
                p.read_data = rx_fifo_q[0];
                rx_fifo_q.delete(0);
                n_rx_reads++;
              end
            end
            REG_IER:     p.read_data = dlab ? dlm_q : DATA_W'(ier_q);
            REG_IIR_FCR: p.read_data = IIR_BASE | irq_ident();
            REG_LCR:     p.read_data = lcr_q;
            REG_MCR:     p.read_data = DATA_W'(mcr_q);
            REG_LSR: begin
              p.read_data = LSR_BASE | (rx_fifo_q.size() != 0 ? LSR_DR : '0) |
                            (overrun_q ? LSR_OE : '0);
              overrun_q = 1'b0;
            end
            REG_SCR:     p.read_data = scr_q;
            default:     p.read_data = '0;
          endcase
        end else begin
          case (a)
            REG_DATA: begin
              if (dlab) begin
                dll_q = r.wdata;
              end else if (tx_fifo_q.size() < DEPTH) begin
                tx_fifo_q.insert(tx_fifo_q.size(), r.wdata);
              end else begin
                n_tx_drops++;
              end
            end
            REG_IER: begin
              if (dlab) dlm_q = r.wdata;
              else ier_q = r.wdata[IER_W-1:0];
            end
            REG_IIR_FCR: begin
              if (r.wdata[FCR_RX_CLR_BIT]) begin
                rx_fifo_q.delete();
                overrun_q = 1'b0;
              end
              if (r.wdata[FCR_TX_CLR_BIT]) tx_fifo_q.delete();
            end
            REG_LCR: lcr_q = r.wdata;
            REG_MCR: mcr_q = r.wdata[MCR_W-1:0] & MCR_MASK;
            REG_SCR: scr_q = r.wdata;
            default: ;
          endcase
        end
      end
      REQ_ATOMIC: p.bus_error = ERR_ATOMIC;
      REQ_RX: begin
        if (rx_fifo_q.size() >= DEPTH) begin
          overrun_q = 1'b1;
          n_overruns++;
        end else begin
          rx_fifo_q.insert(rx_fifo_q.size(), r.rxb);
          p.rx_accepted = 1'b1;
        end
      end
      REQ_TXPOP: begin
        if (tx_fifo_q.size() != 0) begin
          p.tx_byte  = tx_fifo_q[0];
          tx_fifo_q.delete(0);
          p.tx_valid = 1'b1;
          n_tx_pops++;
        end
      end
      default: ;
    endcase
    if (p.bus_error != ERR_NONE) n_bus_errors++;
    p.irq_level = (irq_ident() != IIR_ID_NONE);
    return p;
  endfunction

  // send one request, optionally after a gap; returns at the accepting edge
  task automatic issue(input logic [TYPE_W-1:0] kind, input logic [OFS_W-1:0] ofs,
                       input logic [AW_W-1:0] aw, input logic [DATA_W-1:0] wd,
                       input logic [DATA_W-1:0] rb);
    bus_req_t r;
    bit       taken;
    r = '{kind, ofs, aw, wd, rb};
    if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.req_type     <= kind;
    req.reg_offset   <= ofs;
    req.access_width <= aw;
    req.write_data   <= wd;
    req.rx_byte      <= rb;
    taken = 1'b0;
    while (!taken) begin
      // ready is stable from the falling edge to the accepting edge
      @(negedge clk);
      taken = (req.ready === 1'b1);
      if (taken) begin
        expected_rsps.insert(expected_rsps.size(), predict_response(r));
        if (kind <= REQ_TXPOP) n_items++;
      end
      @(posedge clk);
    end
  endtask

  task automatic reg_rd(input logic [2:0] a);
    issue(REQ_READ, OFS_W'(a), WIDTH_BYTE, DATA_W'($urandom_range(0, 255)),
          DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic reg_wr(input logic [2:0] a, input logic [DATA_W-1:0] d);
    issue(REQ_WRITE, OFS_W'(a), WIDTH_BYTE, d, DATA_W'($urandom_range(0, 255)));
  endtask

  function automatic int unsigned idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // result side backpressure in random bursts
  always begin
    @(posedge clk);
    if (quiet || rst || $urandom_range(1, 100) > stall_pct) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      rsp.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result checker, sampled on the falling edge ahead of the accepting edge
  always @(negedge clk) begin
    if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got_rsp = '{rsp.read_data, rsp.bus_error, rsp.rx_accepted, rsp.tx_valid,
                  rsp.tx_byte, rsp.irq_level};
      if (expected_rsps.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result: expected none, actual %0h", $time, got_rsp);
      end else begin
        want_rsp = expected_rsps[0];
        expected_rsps.delete(0);
        n_checked++;
        check_field("read_data", want_rsp.read_data, got_rsp.read_data);
        check_field("bus_error", DATA_W'(want_rsp.bus_error), DATA_W'(got_rsp.bus_error));
        check_field("rx_accepted", DATA_W'(want_rsp.rx_accepted),
                    DATA_W'(got_rsp.rx_accepted));
        check_field("tx_valid", DATA_W'(want_rsp.tx_valid), DATA_W'(got_rsp.tx_valid));
        check_field("tx_byte", want_rsp.tx_byte, got_rsp.tx_byte);
        check_field("irq_level", DATA_W'(want_rsp.irq_level), DATA_W'(got_rsp.irq_level));
      end
    end
  end

  // reset values, error responses, empty fifos and ignored request types
  task automatic test_reset_and_errors();
    reg_rd(REG_IIR_FCR);
    reg_rd(REG_LSR);
    reg_rd(REG_DATA);
    issue(REQ_TXPOP, 8'h00, WIDTH_BYTE, 8'h00, 8'h00);
    issue(REQ_READ, OFS_W'(REG_SCR), WIDTH_HALF, 8'h00, 8'h00);
    // width is checked ahead of the offset
    issue(REQ_WRITE, OFS_LAST + 8'd2, WIDTH_DWORD, 8'hFF, 8'hFF);
    issue(REQ_READ, OFS_LAST + 8'd1, WIDTH_BYTE, 8'h00, 8'h00);
    issue(REQ_WRITE, 8'hFF, WIDTH_BYTE, 8'hFF, 8'h00);
    issue(REQ_ATOMIC, 8'hC8, WIDTH_DWORD, 8'hFF, 8'hFF);
    issue(REQ_ATOMIC, OFS_W'(REG_DATA), WIDTH_BYTE, 8'h00, 8'h00);
    issue(REQ_UNUSED_LO, OFS_W'(REG_DATA), WIDTH_BYTE, 8'hFF, 8'hFF);
    issue(REQ_UNUSED_HI, 8'hFF, WIDTH_DWORD, 8'h00, 8'h00);
  endtask

  // the registers but lsr, divisor latch access and the receive over transmit interrupt priority
  task automatic test_register_map();
    reg_wr(REG_IER, 8'hFF);
    reg_rd(REG_IER);
    reg_rd(REG_IIR_FCR);
    reg_wr(REG_LCR, 8'h83);
    reg_wr(REG_DATA, 8'hA5);
    reg_wr(REG_IER, 8'hFF);
    reg_rd(REG_DATA);
    reg_rd(REG_IER);
    reg_wr(REG_LCR, 8'h1B);
    reg_rd(REG_LCR);
    reg_wr(REG_MCR, 8'hFF);
    reg_rd(REG_MCR);
    reg_wr(REG_SCR, 8'h5A);
    reg_rd(REG_SCR);
    reg_wr(REG_MSR, 8'hFF);
    reg_rd(REG_MSR);
    issue(REQ_RX, 8'h00, WIDTH_BYTE, 8'h00, 8'hFF);
    reg_rd(REG_IIR_FCR);
    reg_rd(REG_DATA);
    // fifo enable with both clear bits
    reg_wr(REG_IIR_FCR, 8'hFF);
  endtask

  // fill both fifos past the top, overrun reporting and clearing
  task automatic test_fifo_limits();
    reg_wr(REG_LCR, 8'h03);
    reg_wr(REG_IER, 8'h07);
    repeat (DEPTH + 1) issue(REQ_RX, 8'h00, WIDTH_BYTE, 8'h00,
                             DATA_W'($urandom_range(0, 255)));
    reg_rd(REG_IIR_FCR);
    reg_rd(REG_LSR);
    repeat (DEPTH + 1) reg_rd(REG_DATA);
    repeat (DEPTH + 1) reg_wr(REG_DATA, DATA_W'($urandom_range(0, 255)));
    reg_rd(REG_IIR_FCR);
    repeat (DEPTH + 1) issue(REQ_TXPOP, 8'h00, WIDTH_BYTE, 8'h00, 8'h00);
    // overrun pending, then cleared by the receive fifo reset
    repeat (DEPTH + 2) issue(REQ_RX, 8'h00, WIDTH_BYTE, 8'h00,
                             DATA_W'($urandom_range(0, 255)));
    reg_wr(REG_IIR_FCR, 8'h03);
    reg_rd(REG_LSR);
  endtask

  // random bursts of well-formed traffic mixed with noise
  task automatic test_random_traffic();
    int unsigned       len;
    int unsigned       pick;
    logic [2:0]        a;
    logic [DATA_W-1:0] d;
    while (n_items < ITEMS_TARGET) begin
      if (n_items + QUIET_ITEMS >= ITEMS_TARGET) quiet = 1'b1;
      gap_pct   = idle_pct();
      stall_pct = idle_pct();
      len       = $urandom_range(4, 24);
      case ($urandom_range(0, 9))
        // serial line arrivals
        0, 1: repeat (len) issue(REQ_RX, OFS_W'($urandom_range(0, 255)),
                                 AW_W'($urandom_range(0, 3)),
                                 DATA_W'($urandom_range(0, 255)),
                                 DATA_W'($urandom_range(0, 255)));
        // transmit holding writes, mostly with the divisor latch closed
        2, 3: begin
          if (lcr_q[LCR_DLAB_BIT] && $urandom_range(0, 3) != 0)
            reg_wr(REG_LCR, DATA_W'($urandom_range(0, 127)));
          repeat (len) reg_wr(REG_DATA, DATA_W'($urandom_range(0, 255)));
        end
        // receive drain with status polling
        4: repeat (len) begin
          pick = $urandom_range(0, 5);
          reg_rd(pick == 0 ? REG_LSR : (pick == 1 ? REG_IIR_FCR : REG_DATA));
        end
        5: repeat (len) issue(REQ_TXPOP, OFS_W'($urandom_range(0, 255)),
                              AW_W'($urandom_range(0, 3)),
                              DATA_W'($urandom_range(0, 255)),
                              DATA_W'($urandom_range(0, 255)));
        // register reads and writes anywhere in the map
        6, 7: repeat (len) begin
          a = 3'($urandom_range(0, 7));
          d = DATA_W'($urandom_range(0, 255));
          if (a == REG_LCR && $urandom_range(0, 2) != 0) d[LCR_DLAB_BIT] = 1'b0;
          if ($urandom_range(0, 1) == 0) reg_rd(a);
          else reg_wr(a, d);
        end
        // anything at all
        8: repeat (len) issue(TYPE_W'($urandom_range(0, 7)), OFS_W'($urandom_range(0, 255)),
                              AW_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)),
                              DATA_W'($urandom_range(0, 255)));
        // bus accesses with random width and offset, mostly errors
        default: repeat (len) issue(TYPE_W'($urandom_range(REQ_READ, REQ_ATOMIC)),
                                    OFS_W'($urandom_range(0, 255)),
                                    AW_W'($urandom_range(0, 3)),
                                    DATA_W'($urandom_range(0, 255)),
                                    DATA_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.req_type     <= REQ_READ;
    req.reg_offset   <= '0;
    req.access_width <= WIDTH_BYTE;
    req.write_data   <= '0;
    req.rx_byte      <= '0;
    rsp.ready        <= 1'b0;
    lcr_q = '0; dll_q = '0; dlm_q = '0; scr_q = '0;
    ier_q = '0; mcr_q = '0; overrun_q = 1'b0;
    gap_pct   = 20;
    stall_pct = 20;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_and_errors();
    test_register_map();
    test_fifo_limits();
    test_random_traffic();

    // let every outstanding result come back
    req.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d results checked, %0d bus errors, %0d overruns",
             n_items, n_checked, n_bus_errors, n_overruns);
    $display("fifo traffic: %0d bytes read back, %0d bytes popped, %0d writes dropped",
             n_rx_reads, n_tx_pops, n_tx_drops);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
